/* hw/rtl/jgm_pkg.sv */
// ----------------------------------------------------------------------------
// jgm_pkg: shared types and constants for the joystick front end
// Payload structs, register indexes, sequencer states, fixed widths and the lane control bundle.
// ----------------------------------------------------------------------------
package jgm_pkg;

  localparam int AdcBits   = 10;
  localparam int HalfScale = 1 << (AdcBits - 1);
  localparam int CenterW   = 14;
  localparam int CarryW    = 12;
  localparam int AxisW     = AdcBits + 2;  // centred axis value, signed
  localparam int AccW      = 15;           // carry plus deadzoned axis
  localparam int DivW      = 10;
  localparam int CntW      = 4;

  typedef enum logic [2:0] {
    RegMode    = 3'd0,
    RegDead    = 3'd1,
    RegDivFast = 3'd2,
    RegDivSlow = 3'd3,
    RegGain    = 3'd4,
    RegInvX    = 3'd5,
    RegInvY    = 3'd6,
    RegCalib   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StCalDiv,
    StWork,
    StOut
  } state_e;

  typedef struct packed {
    logic [9:0] raw_x;
    logic [9:0] raw_y;
    logic [9:0] button_level;
    logic       slow;
    logic       recalibrate;
  } in_t;

  typedef struct packed {
    logic signed [11:0] axis_x;
    logic signed [11:0] axis_y;
    logic               pressed;
    logic signed [7:0]  move_x;
    logic signed [7:0]  move_y;
    logic               calibrated;
  } out_t;

  // control from the sequencer to each lane
  typedef struct packed {
    logic start;       // load operands; begins a divide in mouse mode, latches the axis in gamepad mode
    logic gamepad;     // 1: gamepad scaling, 0: mouse path
    logic done;        // axis is live this beat
  } lane_ctl_t;

endpackage

/* hw/rtl/jgm_divider.sv */
// ----------------------------------------------------------------------------
// jgm_divider: serial signed divider
// Restoring, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module jgm_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [jgm_pkg::AccW-1:0]      num_i,
  input  logic        [jgm_pkg::DivW-1:0]      den_i,
  output logic                                 busy_o,
  output logic signed [jgm_pkg::AccW-1:0]      quo_o,
  output logic signed [jgm_pkg::AccW-1:0]      rem_o
);
  localparam int W = jgm_pkg::AccW;

  logic [W-1:0]            mag_q, mag_d;
  logic [W-1:0]            rem_q, rem_d;
  logic [jgm_pkg::DivW-1:0] den_q, den_d;
  logic                    neg_q, neg_d;
  logic [4:0]              cnt_q, cnt_d;
  logic [W:0]              trial;

  always_comb begin
    mag_d = mag_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    trial = {rem_q, mag_q[W-1]} - {{(W+1-jgm_pkg::DivW){1'b0}}, den_q};
    if (start_i) begin
      neg_d = num_i[W-1];
      mag_d = num_i[W-1] ? W'(-num_i) : W'(num_i);
      rem_d = '0;
      den_d = (den_i == '0) ? jgm_pkg::DivW'(1) : den_i;
      cnt_d = 5'(W);
    end else if (cnt_q != '0) begin
      // shift in one numerator bit, subtract when it fits
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        mag_d = {mag_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], mag_q[W-1]};
        mag_d = {mag_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = neg_q ? W'(-mag_q) : mag_q;
  assign rem_o  = neg_q ? W'(-rem_q) : rem_q;
endmodule

/* hw/rtl/jgm_lane.sv */
// ----------------------------------------------------------------------------
// jgm_lane: one axis of the joystick front end
// Holds centre and carry, forms the axis value, scales it or divides it.
// ----------------------------------------------------------------------------
module jgm_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  jgm_pkg::lane_ctl_t                ctl_i,
  input  logic                              clr_i,      // recalibrate
  input  logic                              acc_i,      // add sample to centre
  input  logic                              cal_start_i,
  input  logic                              cal_load_i,
  input  logic [jgm_pkg::AdcBits-1:0]       raw_i,
  input  logic                              inv_i,
  input  logic [8:0]                        dead_i,
  input  logic [6:0]                        gain_i,
  input  logic [jgm_pkg::CntW-1:0]          nsamp_i,
  input  logic [jgm_pkg::DivW-1:0]          div_i,
  output logic                              busy_o,
  output logic signed [11:0]                axis_o,
  output logic signed [7:0]                 move_o
);
  localparam int CW = jgm_pkg::CenterW;
  localparam int AW = jgm_pkg::AccW;

  logic signed [CW-1:0]             center_q, center_d;
  logic signed [jgm_pkg::CarryW-1:0] carry_q, carry_d;
  logic signed [CW-1:0]             center_acc;
  logic signed [CW-1:0]             axis_v;
  logic signed [CW-1:0]             dz;
  logic signed [AW-1:0]             acc;
  logic signed [AW-1:0]             num;
  logic        [jgm_pkg::DivW-1:0]  den;
  logic signed [AW-1:0]             quo, rem;
  logic signed [CW+8-1:0]           prod;
  logic signed [CW+8-1:0]           scaled;
  logic                             start;
  logic signed [CW-1:0]             rawc;
  logic signed [CW-1:0]             deadv;

  assign rawc  = $signed({{(CW-jgm_pkg::AdcBits){1'b0}}, raw_i});
  assign deadv = $signed({{(CW-9){1'b0}}, dead_i});
  assign center_acc = (clr_i ? '0 : center_q) + rawc - CW'(jgm_pkg::HalfScale);

  // centre the sample, mirror when asked, zero until calibration is done
  always_comb begin
    if (!ctl_i.done) begin
      axis_v = '0;
    end else if (inv_i) begin
      axis_v = CW'(jgm_pkg::HalfScale - 1) - rawc + center_q;
    end else begin
      axis_v = rawc - CW'(jgm_pkg::HalfScale) - center_q;
    end
  end

  // remove deadzone
  always_comb begin
    if (axis_v > 0) begin
      dz = (axis_v > deadv) ? axis_v - deadv : '0;
    end else begin
      dz = (axis_v < -deadv) ? axis_v + deadv : '0;
    end
  end

  assign acc   = AW'(carry_q) + AW'(dz);
  assign start = cal_start_i || (ctl_i.start && !ctl_i.gamepad);
  assign num   = cal_start_i ? AW'(center_d) : acc;
  assign den   = cal_start_i ? jgm_pkg::DivW'(nsamp_i) : div_i;

  jgm_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (busy_o),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  // centre update: clear, accumulate, then load the average
  always_comb begin
    center_d = center_q;
    if (clr_i) center_d = '0;
    if (acc_i) center_d = center_acc;
    if (cal_load_i) center_d = quo[CW-1:0];
  end

  // gamepad scale by gain/32, truncating toward zero
  assign prod   = axis_v * $signed({1'b0, gain_i});
  assign scaled = (prod < 0) ? -((-prod) >>> 5) : (prod >>> 5);

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      if (scaled > 2047) axis_o <= 12'sd2047;
      else if (scaled < -2048) axis_o <= -12'sd2048;
      else axis_o <= scaled[11:0];
    end
  end

  // mouse: carry keeps the remainder, motion saturates
  always_comb begin
    carry_d = carry_q;
    if (ctl_i.done && 1'b0) carry_d = carry_q;
  end

  logic mouse_run_q;
  logic mouse_fin;
  assign mouse_fin = mouse_run_q && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q    <= '0;
      carry_q     <= '0;
      mouse_run_q <= 1'b0;
    end else begin
      center_q <= center_d;
      if (ctl_i.start && !ctl_i.gamepad) mouse_run_q <= 1'b1;
      else if (mouse_fin) mouse_run_q <= 1'b0;
      if (mouse_fin) carry_q <= rem[jgm_pkg::CarryW-1:0];
      else carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mouse_fin) begin
      if (quo > 127) move_o <= 8'sd127;
      else if (quo < -127) move_o <= -8'sd127;
      else move_o <= quo[7:0];
    end
  end
endmodule

/* hw/rtl/joystick_to_gamepad_or_mouse_core.sv */
// ----------------------------------------------------------------------------
// joystick_to_gamepad_or_mouse_core: joystick to gamepad or mouse
// Two axis lanes with serial dividers, a sequencer and a merging output stage.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/ready   | jgm_pkg::in_t
//  out     | output    | out_valid/ready  | jgm_pkg::out_t
//  cfg     | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// One item at a time. Gamepad mode scales the axes without dividing; the
// last calibration tick averages the centres and mouse mode divides the
// motion, each on the 15-step serial divider in the lanes, in turn when both.
// Reset clears centres, carries and count and sets the registers to defaults.
// in_ready is low while an item is at work or its result waits on out_ready.
module joystick_to_gamepad_or_mouse_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jgm_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jgm_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [9:0]     cfg_data_i
);
  jgm_pkg::state_e state_q, state_d;

  logic       mode_q, invx_q, invy_q;
  logic [8:0] dead_q;
  logic [9:0] divf_q, divs_q;
  logic [6:0] gain_q;
  logic [3:0] nsamp_q;
  logic [3:0] cnt_q;
  logic       done_q, slow_q, pressed_q;
  jgm_pkg::in_t item_q;

  logic       acc_go, last_cal, cal_start, cal_load, done_now, bx, by;
  logic [3:0] cnt_eff;
  logic       in_fire, work_start;
  jgm_pkg::lane_ctl_t ctl;
  logic signed [11:0] ax, ay;
  logic signed [7:0]  mx, my;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == jgm_pkg::StIdle);
  assign in_fire     = in_valid_i && in_ready_o;

  // calibration decision on the accepted beat
  assign cnt_eff   = in_data_i.recalibrate ? 4'd0 : cnt_q;
  assign acc_go    = in_fire && (cnt_eff < nsamp_q);
  assign last_cal  = acc_go && (cnt_eff + 4'd1 == nsamp_q);
  assign cal_start = last_cal;
  assign done_now  = in_fire && !acc_go;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jgm_pkg::StIdle:   if (in_fire) state_d = last_cal ? jgm_pkg::StCalDiv
                                                         : jgm_pkg::StWork;
      jgm_pkg::StCalDiv: if (!bx && !by) state_d = jgm_pkg::StWork;
      jgm_pkg::StWork:   if (!mode_q || (!bx && !by && !work_start))
                           state_d = jgm_pkg::StOut;
      jgm_pkg::StOut:    if (out_ready_i) state_d = jgm_pkg::StIdle;
      default:           state_d = jgm_pkg::StIdle;
    endcase
  end

  // one-cycle start pulse on entry to work
  logic work_seen_q;
  assign work_start = (state_q == jgm_pkg::StWork) && !work_seen_q;
  assign cal_load   = (state_q == jgm_pkg::StCalDiv) && !bx && !by && work_seen_q;

  always_comb begin
    ctl.start   = work_start;
    ctl.gamepad = !mode_q;
    ctl.done    = done_q;
  end

  jgm_lane u_lane_x (
    .clk_i, .rst_ni, .ctl_i(ctl),
    .clr_i(in_fire && in_data_i.recalibrate), .acc_i(acc_go),
    .cal_start_i(cal_start), .cal_load_i(cal_load),
    .raw_i(state_q == jgm_pkg::StIdle ? in_data_i.raw_x : item_q.raw_x),
    .inv_i(invx_q), .dead_i(dead_q), .gain_i(gain_q), .nsamp_i(nsamp_q),
    .div_i(slow_q ? divs_q : divf_q),
    .busy_o(bx), .axis_o(ax), .move_o(mx)
  );

  jgm_lane u_lane_y (
    .clk_i, .rst_ni, .ctl_i(ctl),
    .clr_i(in_fire && in_data_i.recalibrate), .acc_i(acc_go),
    .cal_start_i(cal_start), .cal_load_i(cal_load),
    .raw_i(state_q == jgm_pkg::StIdle ? in_data_i.raw_y : item_q.raw_y),
    .inv_i(invy_q), .dead_i(dead_q), .gain_i(gain_q), .nsamp_i(nsamp_q),
    .div_i(slow_q ? divs_q : divf_q),
    .busy_o(by), .axis_o(ay), .move_o(my)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jgm_pkg::StIdle;
      work_seen_q <= 1'b0;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      mode_q <= 1'b0; dead_q <= 9'd15; divf_q <= 10'd100; divs_q <= 10'd250;
      gain_q <= 7'd12; invx_q <= 1'b1; invy_q <= 1'b1; nsamp_q <= 4'd5;
    end else begin
      state_q <= state_d;
      work_seen_q <= (state_d == state_q) &&
                     ((state_q == jgm_pkg::StWork) ||
                      (state_q == jgm_pkg::StCalDiv));
      if (in_fire) begin
        cnt_q  <= acc_go ? cnt_eff + 4'd1 : cnt_eff;
        done_q <= done_now || last_cal;
      end
      // register writes
      if (cfg_valid_i) begin
        unique case (jgm_pkg::reg_idx_e'(cfg_index_i))
          jgm_pkg::RegMode:    mode_q  <= cfg_data_i[0];
          jgm_pkg::RegDead:    dead_q  <= cfg_data_i[8:0];
          jgm_pkg::RegDivFast: divf_q  <= cfg_data_i;
          jgm_pkg::RegDivSlow: divs_q  <= cfg_data_i;
          jgm_pkg::RegGain:    gain_q  <= cfg_data_i[6:0];
          jgm_pkg::RegInvX:    invx_q  <= cfg_data_i[0];
          jgm_pkg::RegInvY:    invy_q  <= cfg_data_i[0];
          jgm_pkg::RegCalib:   nsamp_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // hold the beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q    <= in_data_i;
      slow_q    <= in_data_i.slow;
      pressed_q <= (in_data_i.button_level <= 10'd20);
    end
  end

  // merge the lanes into the result beat
  assign out_valid_o           = (state_q == jgm_pkg::StOut);
  assign out_data_o.axis_x     = mode_q ? 12'sd0 : ax;
  assign out_data_o.axis_y     = mode_q ? 12'sd0 : ay;
  assign out_data_o.pressed    = !mode_q && pressed_q;
  assign out_data_o.move_x     = mode_q ? mx : 8'sd0;
  assign out_data_o.move_y     = mode_q ? my : 8'sd0;
  assign out_data_o.calibrated = done_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !bx && !by) else $error("divider busy while idle");
endmodule
